@@ rtl/assert_macros.svh @@
// Assertion macros shared by the supervisor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define WWS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define WWS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/wws_pkg.sv @@
// Types and constants of the windowed watchdog supervisor.
`timescale 1ns / 1ps
package wws_pkg;

   typedef enum logic [1:0] {
      CMD_ARM       = 2'd0,
      CMD_FEED      = 2'd1,
      CMD_SUPERVISE = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      REG_MAX_FEEDS     = 2'd0,
      REG_MIN_FEEDS     = 2'd1,
      REG_EPOCH_PERIOD  = 2'd2,
      REG_FEED_INTERVAL = 2'd3
   } reg_index_type;

   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [15:0] MAX_FEEDS_RESET     = 16'd64;
   localparam logic [15:0] MIN_FEEDS_RESET     = 16'd1;
   localparam logic [31:0] EPOCH_PERIOD_RESET  = 32'd16000000;
   localparam logic [31:0] FEED_INTERVAL_RESET = 32'd1600000;

   // hw_feed, feed_taken, epoch_closed, two 16-bit counts, 32-bit epochs, armed
   localparam int unsigned RSP_FIELDS_W = 68;
   localparam int unsigned RSP_DATA_W   = 72;

endpackage

@@ rtl/windowed_watchdog_supervisor_unit.sv @@
// Windowed watchdog supervisor: event register, single-pass update, result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
//
//  channel | direction | handshake                 | content
//  --------+-----------+---------------------------+----------------------------------
//  req_    | in        | req_tvalid / req_tready   | tuser command, tdata now_ticks
//  rsp_    | out       | rsp_tvalid / rsp_tready   | tdata status flags and counters
//  csr_    | in/out    | psel, penable, pready     | four configuration registers
//
//  One event per cycle sustained while rsp_tready is high; req reaches rsp via the event and result registers.
//  The event register feeds one pass of two time subtractions, compares and
//  counter updates that writes the state and the result register together.
//  A full result register stalls the event register only when rsp_tready is low.
//  Synchronous reset disarms the supervisor, clears the counters and reloads
//  the configuration defaults; there is no clearing pass.
module windowed_watchdog_supervisor_unit #(
   parameter int unsigned TIME_BITS  = 52,
   parameter int unsigned COUNT_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // stream in
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((TIME_BITS + 7) / 8) * 8 - 1:0] req_tdata,  // now_ticks
   input  logic [1:0]                             req_tuser,  // command
   // stream out
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // hw_feed, feed_taken, epoch_closed, feeds_this_epoch[16], feeds_last_epoch[16],
   // epochs_done[32], armed
   output logic [wws_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   // configuration
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [wws_pkg::CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [wws_pkg::CSR_DATA_W-1:0]         csr_pwdata,
   output logic [wws_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                   csr_pready
);

   // configuration registers
   logic [15:0] max_feeds_ff;
   logic [15:0] min_feeds_ff;
   logic [31:0] epoch_period_ff;
   logic [31:0] feed_interval_ff;

   wws_pkg::reg_index_type csr_index;
   logic                   csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = wws_pkg::reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_feeds_ff     <= wws_pkg::MAX_FEEDS_RESET;
         min_feeds_ff     <= wws_pkg::MIN_FEEDS_RESET;
         epoch_period_ff  <= wws_pkg::EPOCH_PERIOD_RESET;
         feed_interval_ff <= wws_pkg::FEED_INTERVAL_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            wws_pkg::REG_MAX_FEEDS:     max_feeds_ff     <= csr_pwdata[15:0];
            wws_pkg::REG_MIN_FEEDS:     min_feeds_ff     <= csr_pwdata[15:0];
            wws_pkg::REG_EPOCH_PERIOD:  epoch_period_ff  <= csr_pwdata;
            wws_pkg::REG_FEED_INTERVAL: feed_interval_ff <= csr_pwdata;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         wws_pkg::REG_MAX_FEEDS:     csr_prdata = 32'(max_feeds_ff);
         wws_pkg::REG_MIN_FEEDS:     csr_prdata = 32'(min_feeds_ff);
         wws_pkg::REG_EPOCH_PERIOD:  csr_prdata = epoch_period_ff;
         wws_pkg::REG_FEED_INTERVAL: csr_prdata = feed_interval_ff;
      endcase
   end

   // event register
   logic                 in_valid_ff;
   logic [1:0]           in_cmd_ff;
   logic [TIME_BITS-1:0] in_now_ff;

   // result register
   logic                                  rsp_valid_ff;
   logic [wws_pkg::RSP_FIELDS_W-1:0]      rsp_data_ff;
   logic [wws_pkg::RSP_FIELDS_W-1:0]      rsp_data_in;

   logic out_free;
   logic advance;

   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign advance    = in_valid_ff & out_free;
   assign req_tready = ~in_valid_ff | out_free;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = wws_pkg::RSP_DATA_W'(rsp_data_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready & req_tvalid) begin
         in_cmd_ff <= req_tuser;
         in_now_ff <= req_tdata[TIME_BITS-1:0];
      end
   end

   // supervisor state
   logic                  armed_ff,       armed_in;
   logic [COUNT_BITS-1:0] feed_cnt_ff,    feed_cnt_in;
   logic [COUNT_BITS-1:0] prior_feeds_ff, prior_feeds_in;
   logic [31:0]           epoch_cnt_ff,   epoch_cnt_in;
   logic [TIME_BITS-1:0]  epoch_start_ff, epoch_start_in;
   logic [TIME_BITS-1:0]  last_feed_ff,   last_feed_in;

   logic [TIME_BITS-1:0] since_epoch;
   logic [TIME_BITS-1:0] since_feed;
   logic                 below_cap;
   logic                 met_min;
   logic                 period_over;
   logic                 interval_over;
   logic                 hw_feed;
   logic                 feed_taken;
   logic                 epoch_closed;

   assign since_epoch   = in_now_ff - epoch_start_ff;
   assign since_feed    = in_now_ff - last_feed_ff;
   assign period_over   = since_epoch >= TIME_BITS'(epoch_period_ff);
   assign interval_over = since_feed >= TIME_BITS'(feed_interval_ff);
   assign below_cap     = 32'(feed_cnt_ff) < 32'(max_feeds_ff);
   assign met_min       = 32'(feed_cnt_ff) >= 32'(min_feeds_ff);

   always_comb begin
      armed_in       = armed_ff;
      feed_cnt_in    = feed_cnt_ff;
      prior_feeds_in = prior_feeds_ff;
      epoch_cnt_in   = epoch_cnt_ff;
      epoch_start_in = epoch_start_ff;
      last_feed_in   = last_feed_ff;
      hw_feed        = 1'b0;
      feed_taken     = 1'b0;
      epoch_closed   = 1'b0;
      unique case (wws_pkg::cmd_type'(in_cmd_ff))
         wws_pkg::CMD_ARM: begin
            armed_in       = 1'b1;
            feed_cnt_in    = COUNT_BITS'(1);
            prior_feeds_in = '0;
            epoch_cnt_in   = '0;
            epoch_start_in = in_now_ff;
            last_feed_in   = in_now_ff;
            hw_feed        = 1'b1;
            feed_taken     = 1'b1;
         end
         wws_pkg::CMD_FEED: begin
            if (armed_ff && below_cap) begin
               feed_cnt_in  = feed_cnt_ff + COUNT_BITS'(1);
               last_feed_in = in_now_ff;
               hw_feed      = 1'b1;
               feed_taken   = 1'b1;
            end
         end
         wws_pkg::CMD_SUPERVISE: begin
            priority if (!armed_ff) begin
               // disarmed: report only
            end else if (period_over) begin
               // close the epoch; refresh only when enough feeds came in
               if (met_min) begin
                  hw_feed      = 1'b1;
                  last_feed_in = in_now_ff;
               end
               prior_feeds_in = feed_cnt_ff;
               feed_cnt_in    = '0;
               epoch_cnt_in   = epoch_cnt_ff + 32'd1;
               epoch_start_in = in_now_ff;
               epoch_closed   = 1'b1;
            end else if (interval_over && below_cap) begin
               feed_cnt_in  = feed_cnt_ff + COUNT_BITS'(1);
               last_feed_in = in_now_ff;
               hw_feed      = 1'b1;
               feed_taken   = 1'b1;
            end
         end
         default: begin
            // unused command: report only
         end
      endcase
      rsp_data_in = {armed_in, epoch_cnt_in, 16'(prior_feeds_in), 16'(feed_cnt_in),
                     epoch_closed, feed_taken, hw_feed};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff       <= 1'b0;
         feed_cnt_ff    <= '0;
         prior_feeds_ff <= '0;
         epoch_cnt_ff   <= '0;
         epoch_start_ff <= '0;
         last_feed_ff   <= '0;
      end else if (advance) begin
         armed_ff       <= armed_in;
         feed_cnt_ff    <= feed_cnt_in;
         prior_feeds_ff <= prior_feeds_in;
         epoch_cnt_ff   <= epoch_cnt_in;
         epoch_start_ff <= epoch_start_in;
         last_feed_ff   <= last_feed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // a closed epoch never counts a feed and leaves the running count empty
   `WWS_ASSERT(a_close_clears_count, rsp_valid_ff && rsp_data_ff[2] |-> !rsp_data_ff[1] && rsp_data_ff[18:3] == 16'd0, "epoch close with feed counted or count left")
   // a hardware reload only happens once armed
   `WWS_ASSERT(a_hw_feed_armed, rsp_valid_ff && rsp_data_ff[0] |-> rsp_data_ff[67], "hardware feed while disarmed")
   // an arm transaction restarts the epoch bookkeeping
   `WWS_ASSERT(a_arm_restarts, advance && in_cmd_ff == wws_pkg::CMD_ARM |=> armed_ff && epoch_cnt_ff == 32'd0 && feed_cnt_ff == COUNT_BITS'(1), "arm did not restart epoch")
   // reset empties both registers
   `WWS_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid_ff && !in_valid_ff && !armed_ff, "pipeline not empty after reset")

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the windowed watchdog supervisor unit.
`timescale 1ns / 1ps
module tb_top;

   localparam int unsigned REQ_DATA_W = ((52 + 7) / 8) * 8;
   localparam int unsigned STALL_LIMIT = 2000;
   // command code the block ignores
   localparam bit [1:0]    CMD_UNUSED = 2'd3;

   typedef struct packed {
      bit        hw_feed;
      bit        feed_taken;
      bit        epoch_closed;
      bit [15:0] feeds_this_epoch;
      bit [15:0] feeds_last_epoch;
      bit [31:0] epochs_done;
      bit        armed;
   } feed_status_type;

   // Tracks supervisor state, predicts one status per event and checks the returned ones.
   class supervisor_scoreboard;
      bit [15:0]       cap_feeds;
      bit [15:0]       need_feeds;
      bit [31:0]       period_ticks;
      bit [31:0]       interval_ticks;
      bit              is_live;
      bit [15:0]       run_feeds;
      bit [15:0]       prev_count;
      bit [31:0]       closed_epochs;
      bit [51:0]       epoch_start;
      bit [51:0]       last_feed;
      feed_status_type pending_status[$];
      int              errors;

      function new();
         cap_feeds      = wws_pkg::MAX_FEEDS_RESET;
         need_feeds     = wws_pkg::MIN_FEEDS_RESET;
         period_ticks   = wws_pkg::EPOCH_PERIOD_RESET;
         interval_ticks = wws_pkg::FEED_INTERVAL_RESET;
         errors         = 0;
      endfunction

      function void set_reg(wws_pkg::reg_index_type idx, bit [31:0] value);
         case (idx)
            wws_pkg::REG_MAX_FEEDS:     cap_feeds = value[15:0];
            wws_pkg::REG_MIN_FEEDS:     need_feeds = value[15:0];
            wws_pkg::REG_EPOCH_PERIOD:  period_ticks = value;
            wws_pkg::REG_FEED_INTERVAL: interval_ticks = value;
            default: ;
         endcase
      endfunction

      function void check_reg(wws_pkg::reg_index_type idx, logic [31:0] actual);
         bit [31:0] expected;
         case (idx)
            wws_pkg::REG_MAX_FEEDS:    expected = {16'd0, cap_feeds};
            wws_pkg::REG_MIN_FEEDS:    expected = {16'd0, need_feeds};
            wws_pkg::REG_EPOCH_PERIOD: expected = period_ticks;
            default:                   expected = interval_ticks;
         endcase
         compare_field(idx.name(), 64'(expected), 64'(actual));
      endfunction

      function void compare_field(string name, logic [63:0] expected, logic [63:0] actual);
         if (actual !== expected) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, expected, actual);
            errors++;
         end
      endfunction

      function int pending();
         return pending_status.size();
      endfunction

      // Count a feed unless the epoch cap is reached.
      function bit accept_feed(bit [51:0] now);
         if (run_feeds < cap_feeds) begin
            run_feeds = run_feeds + 16'd1;
            last_feed = now;
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function void note_event(bit [1:0] cmd, bit [51:0] now);
         feed_status_type st;
         bit [51:0]       since_epoch;
         bit [51:0]       since_feed;
         st = '0;
         case (cmd)
            wws_pkg::CMD_ARM: begin
               is_live       = 1'b1;
               run_feeds     = 16'd1;
               prev_count    = 16'd0;
               closed_epochs = 32'd0;
               epoch_start   = now;
               last_feed     = now;
               st.hw_feed    = 1'b1;
               st.feed_taken = 1'b1;
            end
            wws_pkg::CMD_FEED: if (is_live) begin
               st.feed_taken = accept_feed(now);
               st.hw_feed    = st.feed_taken;
            end
            wws_pkg::CMD_SUPERVISE: if (is_live) begin
               // differences wrap at the timer width
               since_epoch = now - epoch_start;
               since_feed  = now - last_feed;
               if (since_epoch >= {20'd0, period_ticks}) begin
                  if (run_feeds >= need_feeds) begin
                     st.hw_feed = 1'b1;
                     last_feed  = now;
                  end
                  prev_count      = run_feeds;
                  run_feeds       = 16'd0;
                  closed_epochs   = closed_epochs + 32'd1;
                  epoch_start     = now;
                  st.epoch_closed = 1'b1;
               end else if (since_feed >= {20'd0, interval_ticks}) begin
                  st.feed_taken = accept_feed(now);
                  st.hw_feed    = st.feed_taken;
               end
            end
            default: ;
         endcase
         st.feeds_this_epoch = run_feeds;
         st.feeds_last_epoch = prev_count;
         st.epochs_done      = closed_epochs;
         st.armed            = is_live;
         pending_status.push_back(st);
      endfunction

      function void check_status(logic [wws_pkg::RSP_DATA_W-1:0] data);
         feed_status_type st;
         if (pending_status.size() == 0) begin
            $error("status transaction with no event outstanding: 0x%0h", data);
            errors++;
            return;
         end
         st = pending_status.pop_front();
         compare_field("hw_feed", 64'(st.hw_feed), 64'(data[0]));
         compare_field("feed_taken", 64'(st.feed_taken), 64'(data[1]));
         compare_field("epoch_closed", 64'(st.epoch_closed), 64'(data[2]));
         compare_field("feeds_this_epoch", 64'(st.feeds_this_epoch), 64'(data[18:3]));
         compare_field("feeds_last_epoch", 64'(st.feeds_last_epoch), 64'(data[34:19]));
         compare_field("epochs_done", 64'(st.epochs_done), 64'(data[66:35]));
         compare_field("armed", 64'(st.armed), 64'(data[67]));
      endfunction
   endclass

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [REQ_DATA_W-1:0]            req_tdata;   // now_ticks
   logic [1:0]                       req_tuser;   // command
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   // hw_feed, feed_taken, epoch_closed, feeds_this_epoch, feeds_last_epoch, epochs_done, armed
   logic [wws_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                             csr_psel;
   logic                             csr_penable;
   logic                             csr_pwrite;
   logic [wws_pkg::CSR_ADDR_W-1:0]   csr_paddr;
   logic [wws_pkg::CSR_DATA_W-1:0]   csr_pwdata;
   logic [wws_pkg::CSR_DATA_W-1:0]   csr_prdata;
   logic                             csr_pready;

   supervisor_scoreboard sb = new();
   bit          quiet_tail;
   bit          rsp_hold_req = 1'b0;
   bit [51:0]   tick_now;
   int unsigned stall_count = 0;

   windowed_watchdog_supervisor_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Receiver: random stall bursts, plus one long hold-off on request.
   initial begin
      int unsigned stall_left;
      bit          hold_done;
      stall_left = 0;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req && !hold_done) begin
            hold_done  = 1'b1;
            stall_left = 60;
         end else if (stall_left == 0 && !quiet_tail && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 9);
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_status(rsp_tdata);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         stall_count <= 0;
      end else begin
         stall_count <= stall_count + 1;
         if (stall_count >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Offer one event and hold it until the block takes it; returns at a falling edge.
   task automatic send_event(bit [1:0] cmd, bit [51:0] now);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {{(REQ_DATA_W - 52){1'b0}}, now};
      do @(posedge clock); while (!req_tready);
      sb.note_event(cmd, now);
      @(negedge clock);
   endtask

   // Write one register, then read it back.
   task automatic program_reg(wws_pkg::reg_index_type idx, bit [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_reg(idx, value);
      @(negedge clock);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.check_reg(idx, csr_prdata);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Drop valid, let every status come back, then program all four registers.
   task automatic reconfigure(bit [15:0] cap, bit [15:0] need, bit [31:0] period,
                              bit [31:0] interval);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
      program_reg(wws_pkg::REG_MAX_FEEDS, {16'd0, cap});
      program_reg(wws_pkg::REG_MIN_FEEDS, {16'd0, need});
      program_reg(wws_pkg::REG_EPOCH_PERIOD, period);
      program_reg(wws_pkg::REG_FEED_INTERVAL, interval);
   endtask

   function automatic longint unsigned rand_upto(longint unsigned lim);
      longint unsigned r;
      r = {$urandom(), $urandom()};
      return r % (lim + 1);
   endfunction

   // Armed sequence with random timing: mostly steps near the feed interval,
   // some near the epoch period, a few repeats and full-range timer jumps.
   task automatic run_random(int count, bit pressure);
      int unsigned     pick;
      bit [1:0]        cmd;
      longint unsigned ivl;
      longint unsigned per;
      ivl = 64'(sb.interval_ticks);
      per = 64'(sb.period_ticks);
      send_event(wws_pkg::CMD_ARM, tick_now);
      for (int i = 1; i < count; i++) begin
         if (pressure && i == 20) rsp_hold_req = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            tick_now = {20'($urandom_range(0, 20'hFFFFF)), $urandom()};
         end else if (pick >= 8 && pick < 75) begin
            tick_now = tick_now + 52'(rand_upto(ivl + ivl / 2));
         end else if (pick >= 75) begin
            tick_now = tick_now + 52'(rand_upto(per + per / 4));
         end
         pick = $urandom_range(0, 99);
         if (pick < 4)       cmd = wws_pkg::CMD_ARM;
         else if (pick < 8)  cmd = CMD_UNUSED;
         else if (pick < 48) cmd = wws_pkg::CMD_FEED;
         else                cmd = wws_pkg::CMD_SUPERVISE;
         send_event(cmd, tick_now);
      end
   endtask

   initial begin
      bit [51:0] t0;
      bit [51:0] t1;
      quiet_tail   = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset configuration: unarmed events, unused command, arm, feeds, closes, re-arm.
      t0 = 52'd1000;
      send_event(wws_pkg::CMD_FEED, 52'd5);
      send_event(wws_pkg::CMD_SUPERVISE, 52'd6);
      send_event(CMD_UNUSED, 52'd7);
      send_event(wws_pkg::CMD_ARM, t0);
      send_event(wws_pkg::CMD_FEED, t0 + 52'd10);
      send_event(wws_pkg::CMD_SUPERVISE, t0 + 52'd100);
      send_event(wws_pkg::CMD_SUPERVISE, t0 + 52'd1600010);
      send_event(wws_pkg::CMD_SUPERVISE, t0 + 52'd16000000);
      send_event(wws_pkg::CMD_SUPERVISE, t0 + 52'd32000000);
      send_event(CMD_UNUSED, t0 + 52'd32000001);
      send_event(wws_pkg::CMD_ARM, t0 + 52'd32000002);

      // Small cap near timer wrap: cap refusal, refused auto-feed, closes with and without refresh.
      reconfigure(16'd2, 16'd2, 32'd100, 32'd10);
      t1 = 52'hF_FFFF_FFFF_FFF0;
      send_event(wws_pkg::CMD_ARM, t1);
      send_event(wws_pkg::CMD_FEED, t1 + 52'd1);
      send_event(wws_pkg::CMD_FEED, t1 + 52'd2);
      send_event(wws_pkg::CMD_SUPERVISE, t1 + 52'd5);
      send_event(wws_pkg::CMD_SUPERVISE, t1 + 52'd20);
      send_event(wws_pkg::CMD_SUPERVISE, t1 + 52'd100);
      send_event(wws_pkg::CMD_SUPERVISE, t1 + 52'd115);
      send_event(wws_pkg::CMD_FEED, t1 + 52'd116);
      send_event(wws_pkg::CMD_SUPERVISE, t1 + 52'd200);
      send_event(wws_pkg::CMD_SUPERVISE, t1 + 52'd300);
      send_event(wws_pkg::CMD_FEED, 52'hF_FFFF_FFFF_FFFF);

      // Zero cap: arm still feeds; zero minimum refreshes on every close.
      reconfigure(16'd0, 16'd0, 32'd1, 32'd1);
      send_event(wws_pkg::CMD_ARM, 52'd0);
      send_event(wws_pkg::CMD_FEED, 52'd0);
      send_event(wws_pkg::CMD_SUPERVISE, 52'd1);

      tick_now = 52'd12345;
      reconfigure(16'd3, 16'd2, 32'd50, 32'd8);
      run_random(130, 1'b1);
      reconfigure(16'hFFFF, 16'hFFFF, 32'd200, 32'd1);
      run_random(120, 1'b0);
      reconfigure(16'd0, 16'd0, 32'd1, 32'd1);
      run_random(100, 1'b0);
      reconfigure(16'd10, 16'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      run_random(120, 1'b0);
      reconfigure(16'd5, 16'd1, 32'd1000, 32'd30);
      run_random(130, 1'b0);
      reconfigure(16'd64, 16'd1, 32'd16000000, 32'd1600000);
      quiet_tail = 1'b1;
      run_random(130, 1'b0);

      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
